// ----- src/tsart_pkg.sv -----
// types and constants shared by the segment ack and receive tracker
package tsart_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_WINDOW_SCALE = 2'd0;
  localparam logic [1:0] REG_INITIAL_SEND_SEQ = 2'd1;
  localparam logic [1:0] REG_INITIAL_RECV_SEQ = 2'd2;

  localparam logic [1:0] ACK_IGNORED = 2'd0;
  localparam logic [1:0] ACK_NEW = 2'd1;
  localparam logic [1:0] ACK_WINDOW_UPDATE = 2'd2;
  localparam logic [1:0] ACK_DUPLICATE = 2'd3;

  localparam logic [1:0] RETX_NONE = 2'd0;
  localparam logic [1:0] RETX_STOP = 2'd1;
  localparam logic [1:0] RETX_RESTART = 2'd2;

  localparam logic [2:0] RX_NONE = 3'd0;
  localparam logic [2:0] RX_DUP_DROP = 3'd1;
  localparam logic [2:0] RX_ACCEPTED = 3'd2;
  localparam logic [2:0] RX_OUT_OF_ORDER = 3'd3;
  localparam logic [2:0] RX_FULL_DROP = 3'd4;

  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_SEND = 2'd1;
  localparam logic [1:0] TX_SEND_ACK = 2'd2;

  localparam logic [3:0] MAX_WINDOW_SCALE = 4'd14;
  localparam logic [7:0] DUP_LIMIT = 8'd255;

  typedef struct packed {
    logic        mode;
    logic [31:0] ack_num;
    logic [31:0] seq_num;
    logic [15:0] window_raw;
    logic [15:0] payload_len;
    logic [31:0] send_max;
    logic [31:0] send_next;
    logic [31:0] rx_read_ptr;
    logic [16:0] ooo_held;
  } seg_item_t;

  typedef struct packed {
    logic [31:0] acked_bytes;
    logic [1:0]  ack_kind;
    logic [7:0]  dup_count;
    logic [29:0] send_window;
    logic [31:0] send_next_new;
    logic [1:0]  retx_timer;
    logic [2:0]  rx_action;
    logic [15:0] data_offset;
    logic [31:0] data_seq;
    logic [15:0] data_len_out;
    logic [15:0] write_pos;
    logic [1:0]  tx_request;
  } res_item_t;

  typedef struct packed {
    logic [3:0]  window_scale;
    logic        send_load;
    logic        recv_load;
    logic [31:0] load_value;
  } cfg_ctrl_t;

endpackage

// ----- src/tsart_regs.sv -----
// configuration register file on the apb-style port
module tsart_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsart_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tsart_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tsart_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready,
  output tsart_pkg::cfg_ctrl_t               cfg
);
  import tsart_pkg::*;

  logic [3:0]  window_scale;
  logic [31:0] initial_send_seq;
  logic [31:0] initial_recv_seq;
  logic        wr_en;
  logic [1:0]  reg_index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign reg_index = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_scale <= '0;
      initial_send_seq <= '0;
      initial_recv_seq <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_WINDOW_SCALE: begin
          window_scale <= pwdata[3:0];
        end
        REG_INITIAL_SEND_SEQ: begin
          initial_send_seq <= pwdata;
        end
        REG_INITIAL_RECV_SEQ: begin
          initial_recv_seq <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WINDOW_SCALE: prdata = {28'd0, window_scale};
      REG_INITIAL_SEND_SEQ: prdata = initial_send_seq;
      REG_INITIAL_RECV_SEQ: prdata = initial_recv_seq;
      default: prdata = '0;
    endcase
  end

  assign cfg.window_scale = window_scale;
  assign cfg.send_load = wr_en && (reg_index == REG_INITIAL_SEND_SEQ);
  assign cfg.recv_load = wr_en && (reg_index == REG_INITIAL_RECV_SEQ);
  assign cfg.load_value = pwdata;

endmodule

// ----- src/tcp_segment_ack_and_receive_tracker.sv -----
// top level: segment ack classification and in-order receive tracking
// a result is valid once its input has passed the input register and then the result register
// throughput: one segment or drain report per cycle while the result output is not stalled; the
// state update and the result are computed in a single pass from the input register
// reset: rst synchronous active high clears all tracking state and the configuration registers
// no clearing pass; the block takes items in the first cycle after reset
module tcp_segment_ack_and_receive_tracker #(
  parameter int unsigned RX_BUFFER_BYTES = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               seg_valid,
  output logic                               seg_stall,
  input  tsart_pkg::seg_item_t               seg,
  output logic                               res_valid,
  input  logic                               res_stall,
  output tsart_pkg::res_item_t               res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsart_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tsart_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tsart_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import tsart_pkg::*;

  localparam int PW = $clog2(RX_BUFFER_BYTES);
  localparam int MOD_STEPS = 6;
  localparam longint unsigned WRAP_MOD = 64'd4294967296 % RX_BUFFER_BYTES;
  localparam logic [PW+1:0] N_EXT = (PW+2)'(RX_BUFFER_BYTES);
  localparam logic [PW+1:0] WRAP_ADJ = (PW+2)'(RX_BUFFER_BYTES - WRAP_MOD);
  localparam logic [31:0] N_32 = 32'(RX_BUFFER_BYTES);
  localparam logic [33:0] N_34 = 34'(RX_BUFFER_BYTES);

  cfg_ctrl_t cfg;

  // pipeline control
  logic        seg_accept;
  logic        advance;
  logic        item_valid;
  seg_item_t   item;
  logic [PW-1:0] plen_mod;
  logic [PW-1:0] plen_mod_in;
  res_item_t   res_next;

  // tracking state
  logic [31:0] oldest_unacked;
  logic [29:0] send_window_reg;
  logic [7:0]  dup_ack_count;
  logic [31:0] tx_ring_head;
  logic [31:0] next_expected;
  logic [31:0] rx_ring_tail;
  logic [PW-1:0] ring_pos;

  logic [31:0] oldest_unacked_next;
  logic [29:0] send_window_reg_next;
  logic [7:0]  dup_ack_count_next;
  logic [31:0] tx_ring_head_next;
  logic [31:0] next_expected_next;
  logic [31:0] rx_ring_tail_next;
  logic [PW-1:0] ring_pos_next;

  // ack side
  logic [3:0]  scale;
  logic [29:0] win;
  logic [31:0] d_ack_ou;
  logic [31:0] d_ack_max;
  logic [31:0] d_ack_snxt;
  logic        ack_after_ou;
  logic        ack_after_max;
  logic        ack_after_snxt;
  logic        new_ack;

  // payload side
  logic [31:0] plen32;
  logic [31:0] d_seq_ne;
  logic [31:0] d_ne_seq;
  logic        seq_before;
  logic        full_dup;
  logic [31:0] keep_seq;
  logic [15:0] keep_len;
  logic [15:0] keep_offset;
  logic        in_order;
  logic [32:0] used;
  logic [33:0] need;
  logic        fits;

  // ring advance
  logic [15:0] add_len;
  logic [31:0] add_len32;
  logic [PW+1:0] add_mod;
  logic [32:0] tail_sum;
  logic [PW+1:0] pos_t0;
  logic [PW+1:0] pos_t1;
  logic [PW+1:0] pos_t2;
  logic [PW+15:0] pos_ext;
  logic [15:0] pos16;

  tsart_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance = item_valid && (!res_valid || !res_stall);
  assign seg_stall = item_valid && !advance;
  assign seg_accept = seg_valid && !seg_stall;

  // payload length reduced modulo the ring size, restoring compare-subtract
  always_comb begin
    logic [31:0] r;
    r = {16'd0, seg.payload_len};
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (N_32 << k)) begin
        r = r - (N_32 << k);
      end
    end
    plen_mod_in = r[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (seg_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_accept) begin
      item <= seg;
      plen_mod <= plen_mod_in;
    end
  end

  // acknowledgment checks, serial-number compare
  always_comb begin
    scale = (cfg.window_scale > MAX_WINDOW_SCALE) ? MAX_WINDOW_SCALE : cfg.window_scale;
    win = 30'(item.window_raw) << scale;
    d_ack_ou = item.ack_num - oldest_unacked;
    d_ack_max = item.ack_num - item.send_max;
    d_ack_snxt = item.ack_num - item.send_next;
    ack_after_ou = (d_ack_ou != '0) && !d_ack_ou[31];
    ack_after_max = (d_ack_max != '0) && !d_ack_max[31];
    ack_after_snxt = (d_ack_snxt != '0) && !d_ack_snxt[31];
    new_ack = ack_after_ou && !ack_after_max;
  end

  // trimming and room check
  always_comb begin
    plen32 = {16'd0, item.payload_len};
    d_seq_ne = item.seq_num - next_expected;
    d_ne_seq = next_expected - item.seq_num;
    seq_before = d_seq_ne[31];
    full_dup = seq_before && (d_ne_seq >= plen32);
    keep_seq = seq_before ? next_expected : item.seq_num;
    keep_len = seq_before ? (item.payload_len - d_ne_seq[15:0]) : item.payload_len;
    keep_offset = seq_before ? d_ne_seq[15:0] : 16'd0;
    in_order = (keep_seq == next_expected);
    used = {1'b0, rx_ring_tail - item.rx_read_ptr} + {16'd0, item.ooo_held};
    need = {1'b0, used} + {18'd0, keep_len};
    fits = (need <= N_34);
  end

  // ring tail and ring position advance, wrap of the 32-bit tail folded back in
  always_comb begin
    add_len = item.mode ? item.payload_len : keep_len;
    add_len32 = {16'd0, add_len};
    add_mod = item.mode ? {2'b00, plen_mod} : add_len32[PW+1:0];
    tail_sum = {1'b0, rx_ring_tail} + {1'b0, add_len32};
    pos_t0 = {2'b00, ring_pos} + add_mod + (tail_sum[32] ? WRAP_ADJ : '0);
    pos_t1 = (pos_t0 >= N_EXT) ? (pos_t0 - N_EXT) : pos_t0;
    pos_t2 = (pos_t1 >= N_EXT) ? (pos_t1 - N_EXT) : pos_t1;
    pos_ext = {16'd0, ring_pos};
    pos16 = pos_ext[15:0];
  end

  always_comb begin
    oldest_unacked_next = oldest_unacked;
    send_window_reg_next = send_window_reg;
    dup_ack_count_next = dup_ack_count;
    tx_ring_head_next = tx_ring_head;
    next_expected_next = next_expected;
    rx_ring_tail_next = rx_ring_tail;
    ring_pos_next = ring_pos;

    res_next = '0;
    res_next.send_next_new = item.send_next;
    res_next.data_seq = item.seq_num;
    res_next.ack_kind = ACK_IGNORED;
    res_next.retx_timer = RETX_NONE;
    res_next.rx_action = RX_NONE;
    res_next.tx_request = TX_NONE;

    if (item.mode) begin
      // drain report from the reassembly queue
      res_next.data_seq = next_expected;
      res_next.data_len_out = item.payload_len;
      res_next.write_pos = pos16;
      next_expected_next = next_expected + plen32;
      rx_ring_tail_next = tail_sum[31:0];
      ring_pos_next = pos_t2[PW-1:0];
    end else begin
      if (new_ack) begin
        res_next.acked_bytes = d_ack_ou;
        res_next.ack_kind = ACK_NEW;
        oldest_unacked_next = item.ack_num;
        if (ack_after_snxt) begin
          res_next.send_next_new = item.ack_num;
        end
        dup_ack_count_next = '0;
        tx_ring_head_next = tx_ring_head + d_ack_ou;
        send_window_reg_next = win;
        res_next.retx_timer = (item.ack_num == item.send_max) ? RETX_STOP : RETX_RESTART;
      end else if (item.ack_num == oldest_unacked) begin
        if (win > send_window_reg) begin
          send_window_reg_next = win;
          res_next.ack_kind = ACK_WINDOW_UPDATE;
        end else if ((item.payload_len == '0) && (oldest_unacked != item.send_max)) begin
          send_window_reg_next = win;
          if (dup_ack_count < DUP_LIMIT) begin
            dup_ack_count_next = dup_ack_count + 8'd1;
          end
          res_next.ack_kind = ACK_DUPLICATE;
        end
      end

      if (item.payload_len == '0) begin
        res_next.tx_request = TX_SEND;
      end else if (full_dup) begin
        res_next.rx_action = RX_DUP_DROP;
        res_next.data_offset = item.payload_len;
        res_next.data_seq = item.seq_num + plen32;
        res_next.tx_request = TX_SEND_ACK;
      end else begin
        res_next.data_seq = keep_seq;
        res_next.data_len_out = keep_len;
        res_next.data_offset = keep_offset;
        if (in_order) begin
          if (fits) begin
            res_next.rx_action = RX_ACCEPTED;
            res_next.write_pos = pos16;
            rx_ring_tail_next = tail_sum[31:0];
            ring_pos_next = pos_t2[PW-1:0];
            next_expected_next = next_expected + add_len32;
            res_next.tx_request = (dup_ack_count_next != '0) ? TX_SEND_ACK : TX_SEND;
          end else begin
            res_next.rx_action = RX_FULL_DROP;
            res_next.tx_request = TX_NONE;
          end
        end else begin
          res_next.rx_action = RX_OUT_OF_ORDER;
          res_next.tx_request = TX_SEND_ACK;
        end
      end
    end

    res_next.dup_count = dup_ack_count_next;
    res_next.send_window = send_window_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_unacked <= '0;
      send_window_reg <= '0;
      dup_ack_count <= '0;
      tx_ring_head <= '0;
      next_expected <= '0;
      rx_ring_tail <= '0;
      ring_pos <= '0;
    end else begin
      if (advance) begin
        oldest_unacked <= oldest_unacked_next;
        send_window_reg <= send_window_reg_next;
        dup_ack_count <= dup_ack_count_next;
        tx_ring_head <= tx_ring_head_next;
        next_expected <= next_expected_next;
        rx_ring_tail <= rx_ring_tail_next;
        ring_pos <= ring_pos_next;
      end
      if (cfg.send_load) begin
        oldest_unacked <= cfg.load_value;
      end
      if (cfg.recv_load) begin
        next_expected <= cfg.load_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_acked_matches_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.ack_kind == ACK_NEW) == (res.acked_bytes != '0)))
    else $error("acked byte count disagrees with ack kind");

  a_ring_pos_range: assert property (@(posedge clk) disable iff (rst)
    ({2'b00, ring_pos} < N_EXT))
    else $error("ring position outside the receive ring");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> (item_valid && res_valid && res_stall))
    else $error("input stalled without a blocked result");

  a_dup_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.rx_action == RX_DUP_DROP)) |->
      ((res.data_len_out == '0) && (res.tx_request == TX_SEND_ACK)))
    else $error("duplicate drop carries kept bytes");

  a_full_drop_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.rx_action == RX_FULL_DROP)) |->
      ((res.write_pos == '0) && (res.tx_request == TX_NONE)))
    else $error("buffer full drop with a write position or transmit");
`endif

endmodule

// ----- tb/tsart_tb_pkg.sv -----
// scoreboard for the segment ack and receive tracker: expected results and field checks
`timescale 1ns / 100ps
package tsart_tb_pkg;
  import tsart_pkg::*;

  localparam logic [32:0] RX_RING_BYTES = 33'd65536;

  class ack_rx_scoreboard;
    logic [3:0]  win_scale;
    logic [31:0] oldest_unacked;
    logic [31:0] send_window;
    logic [7:0]  dup_acks;
    logic [31:0] next_expected;
    logic [31:0] rx_tail;
    res_item_t   results_due[$];
    int          failures;

    function new();
      win_scale      = '0;
      oldest_unacked = '0;
      send_window    = '0;
      dup_acks       = '0;
      next_expected  = '0;
      rx_tail        = '0;
      failures       = 0;
    endfunction

    function bit seq_after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
    endfunction

    function bit seq_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WINDOW_SCALE:     win_scale = value[3:0];
        REG_INITIAL_SEND_SEQ: oldest_unacked = value;
        REG_INITIAL_RECV_SEQ: next_expected = value;
        default: ;
      endcase
    endfunction

    function res_item_t track_segment(seg_item_t s);
      res_item_t   r;
      logic [31:0] win;
      logic [31:0] plen;
      logic [31:0] sq;
      logic [31:0] ln;
      logic [31:0] overlap;
      logic [32:0] used;
      logic [32:0] room;
      bit          dropped;
      r = '0;
      r.data_seq = s.seq_num;
      r.send_next_new = s.send_next;
      r.ack_kind = ACK_IGNORED;
      r.retx_timer = RETX_NONE;
      r.rx_action = RX_NONE;
      r.tx_request = TX_NONE;
      plen = {16'd0, s.payload_len};
      dropped = 1'b0;
      if (s.mode) begin
        // drain report from the reassembly queue
        r.data_seq = next_expected;
        r.data_len_out = s.payload_len;
        r.write_pos = rx_tail[15:0];
        next_expected = next_expected + plen;
        rx_tail = rx_tail + plen;
      end else begin
        win = {16'd0, s.window_raw} <<
              ((win_scale > MAX_WINDOW_SCALE) ? MAX_WINDOW_SCALE : win_scale);
        if (seq_after(s.ack_num, oldest_unacked) && !seq_after(s.ack_num, s.send_max)) begin
          r.acked_bytes = s.ack_num - oldest_unacked;
          oldest_unacked = s.ack_num;
          if (seq_after(oldest_unacked, s.send_next)) r.send_next_new = oldest_unacked;
          dup_acks = '0;
          send_window = win;
          r.retx_timer = (oldest_unacked == s.send_max) ? RETX_STOP : RETX_RESTART;
          r.ack_kind = ACK_NEW;
        end else if (s.ack_num == oldest_unacked) begin
          if (win > send_window) begin
            send_window = win;
            r.ack_kind = ACK_WINDOW_UPDATE;
          end else if (plen == 32'd0 && oldest_unacked != s.send_max) begin
            send_window = win;
            if (dup_acks != DUP_LIMIT) dup_acks = dup_acks + 8'd1;
            r.ack_kind = ACK_DUPLICATE;
          end
        end

        if (plen == 32'd0) begin
          r.tx_request = TX_SEND;
        end else begin
          sq = s.seq_num;
          ln = plen;
          if (seq_before(sq, next_expected)) begin
            overlap = next_expected - sq;
            if (overlap >= ln) begin
              r.rx_action = RX_DUP_DROP;
              r.data_offset = s.payload_len;
              r.data_seq = s.seq_num + plen;
              r.tx_request = TX_SEND_ACK;
              dropped = 1'b1;
            end else begin
              r.data_offset = overlap[15:0];
              sq = sq + overlap;
              ln = ln - overlap;
            end
          end
          if (!dropped) begin
            r.data_seq = sq;
            r.data_len_out = ln[15:0];
            if (sq == next_expected) begin
              used = {1'b0, rx_tail - s.rx_read_ptr} + 33'(s.ooo_held);
              room = (used >= RX_RING_BYTES) ? 33'd0 : RX_RING_BYTES - used;
              if ({1'b0, ln} <= room) begin
                r.rx_action = RX_ACCEPTED;
                r.write_pos = rx_tail[15:0];
                rx_tail = rx_tail + ln;
                next_expected = next_expected + ln;
                r.tx_request = (dup_acks != 8'd0) ? TX_SEND_ACK : TX_SEND;
              end else begin
                r.rx_action = RX_FULL_DROP;
                r.tx_request = TX_NONE;
              end
            end else begin
              r.rx_action = RX_OUT_OF_ORDER;
              r.tx_request = TX_SEND_ACK;
            end
          end
        end
      end
      r.dup_count = dup_acks;
      r.send_window = send_window[29:0];
      return r;
    endfunction

    function void note_segment(seg_item_t s);
      results_due.push_back(track_segment(s));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
        return;
      end
      want = results_due.pop_front();
      compare_field("acked_bytes", want.acked_bytes, got.acked_bytes);
      compare_field("ack_kind", 32'(want.ack_kind), 32'(got.ack_kind));
      compare_field("dup_count", 32'(want.dup_count), 32'(got.dup_count));
      compare_field("send_window", 32'(want.send_window), 32'(got.send_window));
      compare_field("send_next_new", want.send_next_new, got.send_next_new);
      compare_field("retx_timer", 32'(want.retx_timer), 32'(got.retx_timer));
      compare_field("rx_action", 32'(want.rx_action), 32'(got.rx_action));
      compare_field("data_offset", 32'(want.data_offset), 32'(got.data_offset));
      compare_field("data_seq", want.data_seq, got.data_seq);
      compare_field("data_len_out", 32'(want.data_len_out), 32'(got.data_len_out));
      compare_field("write_pos", 32'(want.write_pos), 32'(got.write_pos));
      compare_field("tx_request", 32'(want.tx_request), 32'(got.tx_request));
    endfunction
  endclass

endpackage

// ----- tb/tb_tcp_segment_ack_and_receive_tracker.sv -----
// testbench top for the segment ack and receive tracker: directed and random segment traffic
`timescale 1ns / 100ps
module tb_tcp_segment_ack_and_receive_tracker;
  import tsart_pkg::*;
  import tsart_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seg_valid = 1'b0;
  logic        seg_stall;
  seg_item_t   seg = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  ack_rx_scoreboard sb;
  int tx_quiet = 0;
  int rx_quiet = 0;
  bit rx_hold_long = 1'b0;

  tcp_segment_ack_and_receive_tracker dut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(20, 60);
    return $urandom_range(0, 10);
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_item(seg_item_t s);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      seg_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    seg = s;
    seg_valid = 1'b1;
    do @(posedge clk); while (seg_stall);
    sb.note_segment(s);
    @(negedge clk);
  endtask

  task automatic settle();
    seg_valid = 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic seg_item_t quiet_segment();
    seg_item_t s;
    s = '0;
    s.ack_num = sb.oldest_unacked;
    s.seq_num = sb.next_expected;
    s.send_max = sb.oldest_unacked;
    s.send_next = sb.oldest_unacked;
    s.rx_read_ptr = sb.rx_tail;
    return s;
  endfunction

  function automatic seg_item_t random_segment(bit dup_storm);
    seg_item_t   s;
    logic [31:0] una;
    logic [31:0] ne;
    logic [31:0] span;
    logic [31:0] occ;
    una = sb.oldest_unacked;
    ne = sb.next_expected;
    s.mode = ($urandom_range(0, 9) == 0);
    span = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5000);
    s.send_max = una + span;
    s.send_next = ($urandom_range(0, 4) == 0) ? $urandom : una + $urandom_range(0, span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s.ack_num = una + $urandom_range(1, (span == 0) ? 1 : span);
      4, 5:       s.ack_num = una;
      6:          s.ack_num = s.send_max;
      7:          s.ack_num = una - $urandom_range(1, 1000);
      8:          s.ack_num = s.send_max + $urandom_range(1, 1000);
      default:    s.ack_num = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       s.window_raw = 16'h0000;
      1:       s.window_raw = 16'hFFFF;
      default: s.window_raw = 16'($urandom);
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: s.payload_len = 16'd0;
      5, 6, 7:       s.payload_len = 16'($urandom);
      default:       s.payload_len = 16'($urandom_range(1, 1500));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: s.seq_num = ne;
      6:                s.seq_num = ne - $urandom_range(1, 3000);
      7:                s.seq_num = ne + $urandom_range(1, 3000);
      8:                s.seq_num = $urandom;
      default:          s.seq_num = ne - $urandom_range(0, s.payload_len);
    endcase
    case ($urandom_range(0, 3))
      0, 1:    occ = $urandom_range(0, 20000);
      2:       occ = $urandom_range(40000, 70000);
      default: occ = $urandom;
    endcase
    s.rx_read_ptr = sb.rx_tail - occ;
    case ($urandom_range(0, 7))
      0:       s.ooo_held = 17'd65536;
      1:       s.ooo_held = 17'($urandom_range(0, 65536));
      default: s.ooo_held = 17'($urandom_range(0, 2000));
    endcase
    if (dup_storm) begin
      // same ack, no data, no window growth: counts toward saturation
      s.mode = 1'b0;
      s.send_max = una + $urandom_range(1, 100);
      s.ack_num = una;
      s.window_raw = 16'h0000;
      s.payload_len = 16'd0;
    end
    return s;
  endfunction

  task automatic directed_items();
    seg_item_t s;
    // new ack across the wrap, pulls send_next forward
    s = quiet_segment();
    s.send_max = sb.oldest_unacked + 32'h40;
    s.send_next = sb.oldest_unacked + 32'd4;
    s.ack_num = sb.oldest_unacked + 32'h20;
    s.window_raw = 16'hFFFF;
    send_item(s);
    // everything acknowledged: timer stop
    s = quiet_segment();
    s.send_max = sb.oldest_unacked + 32'd8;
    s.send_next = s.send_max;
    s.ack_num = s.send_max;
    s.window_raw = 16'd1;
    send_item(s);
    // window update
    s = quiet_segment();
    s.send_max = sb.oldest_unacked + 32'd100;
    s.window_raw = 16'd2;
    send_item(s);
    // two duplicate acks
    repeat (2) begin
      s = quiet_segment();
      s.send_max = sb.oldest_unacked + 32'd100;
      s.window_raw = 16'd1;
      send_item(s);
    end
    // ack beyond send_max is ignored
    s = quiet_segment();
    s.send_max = sb.oldest_unacked + 32'd100;
    s.ack_num = sb.oldest_unacked + 32'd200;
    send_item(s);
    // in-order data while duplicates are counted
    s = quiet_segment();
    s.send_max = sb.oldest_unacked + 32'd100;
    s.payload_len = 16'd100;
    send_item(s);
    // full duplicate, then one ending exactly at next_expected
    s = quiet_segment();
    s.seq_num = sb.next_expected - 32'd100;
    s.payload_len = 16'd50;
    send_item(s);
    s = quiet_segment();
    s.seq_num = sb.next_expected - 32'd50;
    s.payload_len = 16'd50;
    send_item(s);
    // partial overlap trimmed
    s = quiet_segment();
    s.seq_num = sb.next_expected - 32'd10;
    s.payload_len = 16'd30;
    send_item(s);
    // out-of-order handoff
    s = quiet_segment();
    s.seq_num = sb.next_expected + 32'd100;
    s.payload_len = 16'd10;
    send_item(s);
    // ring full
    s = quiet_segment();
    s.rx_read_ptr = sb.rx_tail - 32'd65000;
    s.ooo_held = 17'd1000;
    s.payload_len = 16'd100;
    send_item(s);
    // exact fit
    s = quiet_segment();
    s.rx_read_ptr = sb.rx_tail - 32'd1000;
    s.ooo_held = 17'd64436;
    s.payload_len = 16'd100;
    send_item(s);
    // reassembly queue holds the whole ring
    s = quiet_segment();
    s.ooo_held = 17'd65536;
    s.payload_len = 16'd1;
    send_item(s);
    // largest in-order segment into an empty ring
    s = quiet_segment();
    s.payload_len = 16'hFFFF;
    send_item(s);
    // drain reports, largest and empty
    s = quiet_segment();
    s.mode = 1'b1;
    s.payload_len = 16'hFFFF;
    send_item(s);
    s = quiet_segment();
    s.mode = 1'b1;
    send_item(s);
    // all ones and all zeros
    s = '1;
    s.mode = 1'b0;
    s.ooo_held = 17'd65536;
    send_item(s);
    s = '0;
    send_item(s);
  endtask

  initial begin
    int i;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apb_write(REG_WINDOW_SCALE, 32'd15);
    apb_write(REG_INITIAL_SEND_SEQ, 32'hFFFF_FFF0);
    apb_write(REG_INITIAL_RECV_SEQ, 32'hFFFF_FF00);
    directed_items();
    settle();

    apb_write(REG_WINDOW_SCALE, 32'd0);
    apb_write(REG_INITIAL_SEND_SEQ, $urandom);
    apb_write(REG_INITIAL_RECV_SEQ, $urandom);
    for (i = 0; i < 600; i++) begin
      if (i == 100) rx_hold_long = 1'b1;
      send_item(random_segment(1'b0));
    end
    settle();

    apb_write(REG_WINDOW_SCALE, 32'd14);
    apb_write(REG_INITIAL_SEND_SEQ, 32'h0000_0000);
    apb_write(REG_INITIAL_RECV_SEQ, 32'hFFFF_FFFF);
    for (i = 0; i < 600; i++) send_item(random_segment(1'b0));
    settle();

    apb_write(REG_WINDOW_SCALE, 32'd7);
    apb_write(REG_INITIAL_SEND_SEQ, 32'h7FFF_FFFF);
    apb_write(REG_INITIAL_RECV_SEQ, 32'h8000_0000);
    for (i = 0; i < 300; i++) send_item(random_segment(1'b1));
    for (i = 0; i < 350; i++) send_item(random_segment(1'b0));
    settle();
    repeat (6) @(negedge clk);

    if (sb.failures == 0 && sb.results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    int n;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      n = draw_wait(rx_quiet);
      if (rx_hold_long) begin
        n = 400;
        rx_hold_long = 1'b0;
      end
      if (n > 0) begin
        res_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      res_stall = 1'b0;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
      @(negedge clk);
    end
  end

endmodule
